// File: design/airtime_duty_cycle_guard_top_defines.svh
`ifndef AIRTIME_DUTY_CYCLE_GUARD_TOP_DEFINES_SVH
`define AIRTIME_DUTY_CYCLE_GUARD_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define ADCG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ADCG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/adcg_pkg.sv
package adcg_pkg;

	localparam int TIME_W = 32;
	localparam int AIR_W = 16;
	localparam int WIN_W = 31;
	localparam int USED_W = 24;
	localparam int CNT_W = 9;
	localparam int ENTRY_W = TIME_W + AIR_W;

	localparam logic [WIN_W-1:0] WINDOW_RST = 31'd3600000;
	localparam logic [USED_W-1:0] BUDGET_RST = 24'd36000;
	localparam logic [USED_W-1:0] USED_MAX = 24'hFFFFFF;

	typedef enum logic [0:0] {
		REG_WINDOW = 1'b0,
		REG_BUDGET = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic action;
		logic [TIME_W-1:0] now_ms;
		logic [AIR_W-1:0] duration_ms;
	} req_t;

	typedef struct packed {
		logic allowed;
		logic [USED_W-1:0] used_ms;
		logic stored;
		logic [CNT_W-1:0] record_count;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_busy;
	} status_t;

endpackage

// File: design/adcg_ram.sv
module adcg_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/adcg_ctrl.sv
module adcg_ctrl
	import adcg_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_action,
	input status_t status,
	output logic req_stall,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = req_action ? ST_FIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!status.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.start = req_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_FIN: begin
				cmd.finish = !status.out_busy;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

// File: design/adcg_dp.sv
module adcg_dp
	import adcg_pkg::*;
#(
	parameter int MAX_RECORDS = 256,
	localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
	localparam int CW = $clog2(MAX_RECORDS + 1),
	localparam int SW = CW + AIR_W
) (
	input logic clk,
	input logic arst_n,
	input req_t req,
	input cmd_t cmd,
	output status_t status,
	input logic cfg_write,
	input cfg_reg_t cfg_index,
	input logic [WIN_W-1:0] cfg_data,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp
);

	req_t item_q;
	logic [SW-1:0] sum_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_q;
	logic [CW-1:0] wr_q;
	logic rd_s1;
	logic [WIN_W-1:0] window_q;
	logic [USED_W-1:0] budget_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic [ENTRY_W-1:0] rdata;
	logic [TIME_W-1:0] rtime;
	logic [AIR_W-1:0] rair;
	logic [TIME_W-1:0] age;
	logic keep;
	logic issue;
	logic room;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [CW-1:0] count_new;
	logic [CW+CNT_W-1:0] count_ext;
	logic [SW+USED_W-1:0] sum_ext;
	logic [USED_W-1:0] used_sat;
	logic [SW+USED_W:0] need;
	rsp_t rsp_d;

	assign rtime = rdata[ENTRY_W-1:AIR_W];
	assign rair = rdata[AIR_W-1:0];
	assign age = item_q.now_ms - rtime;
	assign keep = rd_s1 && (age < {1'b0, window_q});
	assign issue = cmd.scan && (rd_q != count_q);
	assign room = count_q < CW'(MAX_RECORDS);

	assign status.scan_done = (rd_q == count_q) && !rd_s1;
	assign status.out_busy = rsp_valid_q && rsp_stall;

	always_comb begin
		ram_we = keep;
		ram_waddr = wr_q[AW-1:0];
		ram_wdata = rdata;
		if (!keep) begin
			ram_we = cmd.finish && item_q.action && room;
			ram_waddr = count_q[AW-1:0];
			ram_wdata = {item_q.now_ms, item_q.duration_ms};
		end
	end

	adcg_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_RECORDS)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_q[AW-1:0]),
		.rdata(rdata)
	);

	// saturated used sum and exact budget compare
	always_comb begin
		sum_ext = (SW+USED_W)'(sum_q);
		used_sat = (sum_ext > (SW+USED_W)'(USED_MAX)) ? USED_MAX : sum_ext[USED_W-1:0];
		need = (SW+USED_W+1)'(sum_q) + (SW+USED_W+1)'(item_q.duration_ms);
		count_new = item_q.action ? (count_q + CW'(room)) : wr_q;
		count_ext = (CW+CNT_W)'(count_new);
		rsp_d.allowed = !item_q.action && (need <= (SW+USED_W+1)'(budget_q));
		rsp_d.used_ms = used_sat;
		rsp_d.stored = item_q.action && room;
		rsp_d.record_count = count_ext[CNT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			item_q <= req;
		end
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			count_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			rd_s1 <= 1'b0;
			window_q <= WINDOW_RST;
			budget_q <= BUDGET_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_WINDOW: window_q <= cfg_data;
					REG_BUDGET: budget_q <= cfg_data[USED_W-1:0];
					default: ;
				endcase
			end
			rd_s1 <= issue;
			if (issue) begin
				rd_q <= rd_q + CW'(1);
			end
			if (cmd.start && !req.action) begin
				rd_q <= '0;
				wr_q <= '0;
				sum_q <= '0;
			end else if (keep) begin
				wr_q <= wr_q + CW'(1);
				sum_q <= sum_q + SW'(rair);
			end else if (cmd.finish) begin
				count_q <= count_new;
				if (item_q.action && room) begin
					sum_q <= sum_q + SW'(item_q.duration_ms);
				end
			end
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// File: design/airtime_duty_cycle_guard_top.sv
// channel   dir   handshake              payload
// req       in    req_valid/req_stall    req_t (action, now_ms, duration_ms)
// rsp       out   rsp_valid/rsp_stall    rsp_t (allowed, used_ms, stored, record_count)
// cfg       in    cfg_valid/cfg_ready    cfg_index, cfg_data
//
// a check scans every held record in ST_SCAN and then gives its result from ST_FIN:
//   one record read per cycle from the single read port, survivors written back in place
// a record skips the scan and goes straight to ST_FIN; a new request is taken once its result is registered
// reset clears the record count and the sum and loads the config registers with their defaults
// a result held under rsp_stall holds the next request in its final cycle
`include "airtime_duty_cycle_guard_top_defines.svh"

module airtime_duty_cycle_guard_top
	import adcg_pkg::*;
#(
	parameter int MAX_RECORDS = 256
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input cfg_reg_t cfg_index,
	input logic [WIN_W-1:0] cfg_data
);

	cmd_t cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	adcg_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_action(req.action),
		.status(status),
		.req_stall(req_stall),
		.cmd(cmd)
	);

	adcg_dp #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cmd(cmd),
		.status(status),
		.cfg_write(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	`ADCG_ASSERT_NOW(a_stored_not_allowed, rsp_valid && rsp.stored, !rsp.allowed, "record result flagged allowed")
	`ADCG_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "request taken while busy")

endmodule

// File: tb/sv/airtime_duty_cycle_guard_top_test.sv
module airtime_duty_cycle_guard_top_test;
	import adcg_pkg::*;

	localparam int MAX_REC = 256;
	localparam int CYCLE_LIMIT = 1500000;
	localparam bit ACT_CHECK = 1'b0;
	localparam bit ACT_RECORD = 1'b1;

	typedef struct {
		bit is_cfg;
		cfg_reg_t sel;
		logic [WIN_W-1:0] val;
		req_t item;
		int reps;
		bit known;
		rsp_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	cfg_reg_t cfg_index;
	logic [WIN_W-1:0] cfg_data;

	// shadow copy of the airtime history
	logic [TIME_W-1:0] hist_time [MAX_REC];
	logic [AIR_W-1:0] hist_air [MAX_REC];
	int hist_cnt;
	logic [WIN_W-1:0] win_len;
	logic [USED_W-1:0] air_budget;

	rsp_t pending_rsp [$];
	plan_row_t plan [$];
	rsp_t head_rsp;
	bit quiet;
	int errors;
	int rsp_seen;
	int cycles;
	int n_checks;
	int n_denied;
	int n_records;
	int n_drops;
	int n_cfg;

	airtime_duty_cycle_guard_top #(
		.MAX_RECORDS(MAX_REC)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic rsp_t guard_step(req_t r);
		rsp_t o;
		longint unsigned total;
		int keep;
		logic [TIME_W-1:0] age;
		o = '0;
		total = 0;
		if (r.action == ACT_CHECK) begin
			keep = 0;
			for (int k = 0; k < hist_cnt; k++) begin
				age = r.now_ms - hist_time[k];
				if (age < {1'b0, win_len}) begin
					hist_time[keep] = hist_time[k];
					hist_air[keep] = hist_air[k];
					keep++;
				end
			end
			hist_cnt = keep;
			for (int k = 0; k < hist_cnt; k++)
				total += hist_air[k];
			o.allowed = (total + r.duration_ms <= air_budget);
			n_checks++;
			if (!o.allowed)
				n_denied++;
		end else begin
			for (int k = 0; k < hist_cnt; k++)
				total += hist_air[k];
			n_records++;
			if (hist_cnt < MAX_REC) begin
				hist_time[hist_cnt] = r.now_ms;
				hist_air[hist_cnt] = r.duration_ms;
				hist_cnt++;
				o.stored = 1'b1;
			end else begin
				n_drops++;
			end
		end
		o.used_ms = (total > USED_MAX) ? USED_MAX : USED_W'(total);
		o.record_count = CNT_W'(hist_cnt);
		return o;
	endfunction

	function automatic void row_req(bit act, logic [TIME_W-1:0] now, logic [AIR_W-1:0] air,
			int reps);
		plan_row_t r;
		r = '{0, REG_WINDOW, '0, '0, reps, 0, '0};
		r.item.action = act;
		r.item.now_ms = now;
		r.item.duration_ms = air;
		plan.push_back(r);
	endfunction

	function automatic void row_want(bit act, logic [TIME_W-1:0] now, logic [AIR_W-1:0] air,
			bit a, int u, bit s, int c);
		plan_row_t r;
		r = '{0, REG_WINDOW, '0, '0, 1, 1, '0};
		r.item.action = act;
		r.item.now_ms = now;
		r.item.duration_ms = air;
		r.want.allowed = a;
		r.want.used_ms = USED_W'(u);
		r.want.stored = s;
		r.want.record_count = CNT_W'(c);
		plan.push_back(r);
	endfunction

	function automatic void row_cfg(cfg_reg_t sel, logic [WIN_W-1:0] val);
		plan_row_t r;
		r = '{1, sel, val, '0, 0, 0, '0};
		plan.push_back(r);
	endfunction

	task automatic flag_error(string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	task automatic send_req(req_t item, bit known, rsp_t want);
		int gap;
		rsp_t pred;
		gap = draw_gap();
		repeat (gap) @(negedge clk) req_valid = 1'b0;
		@(negedge clk);
		req_valid = 1'b1;
		req = item;
		do @(posedge clk); while (req_stall);
		pred = guard_step(item);
		pending_rsp.push_back(known ? want : pred);
	endtask

	task automatic flush_results();
		@(negedge clk);
		req_valid = 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t sel, logic [WIN_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = sel;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (sel)
			REG_WINDOW: win_len = val;
			REG_BUDGET: air_budget = val[USED_W-1:0];
			default: ;
		endcase
		n_cfg++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// response side: random stall per result
	initial begin
		int n;
		wait (arst_n === 1'b1);
		forever begin
			n = draw_gap();
			repeat (n) @(negedge clk) rsp_stall = 1'b1;
			@(negedge clk);
			rsp_stall = 1'b0;
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_seen++;
			if (pending_rsp.size() == 0) begin
				flag_error($sformatf("result %0d arrived with no request waiting", rsp_seen));
			end else begin
				head_rsp = pending_rsp.pop_front();
				if (rsp !== head_rsp)
					flag_error($sformatf({"result %0d: allowed %0d/%0d used %0d/%0d ",
						"stored %0d/%0d count %0d/%0d (got/expected)"}, rsp_seen,
						rsp.allowed, head_rsp.allowed, rsp.used_ms, head_rsp.used_ms,
						rsp.stored, head_rsp.stored, rsp.record_count,
						head_rsp.record_count));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_rsp.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		req_t item;
		logic [TIME_W-1:0] t_now;
		logic [WIN_W-1:0] win;
		logic [USED_W-1:0] bud;
		int count;
		int step_hi;
		int rec_pct;
		int air_hi;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_WINDOW;
		cfg_data = '0;
		quiet = 1'b0;
		errors = 0;
		rsp_seen = 0;
		cycles = 0;
		n_checks = 0;
		n_denied = 0;
		n_records = 0;
		n_drops = 0;
		n_cfg = 0;
		win_len = WINDOW_RST;
		air_budget = BUDGET_RST;
		hist_cnt = 0;

		// reset values, then window edges and wrap
		row_want(ACT_CHECK, 32'd0, 16'd0, 1, 0, 0, 0);
		row_want(ACT_CHECK, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0, 0);
		row_want(ACT_CHECK, 32'd7, 16'd36000, 1, 0, 0, 0);
		row_want(ACT_CHECK, 32'd7, 16'd36001, 0, 0, 0, 0);
		row_want(ACT_RECORD, 32'd1000, 16'hFFFF, 0, 0, 1, 1);
		row_want(ACT_RECORD, 32'd2000, 16'd0, 0, 65535, 1, 2);
		row_want(ACT_CHECK, 32'd2000, 16'd0, 0, 65535, 0, 2);
		row_want(ACT_CHECK, 32'd3600999, 16'd0, 0, 65535, 0, 2);
		row_want(ACT_CHECK, 32'd3601000, 16'd0, 1, 0, 0, 1);
		row_want(ACT_RECORD, 32'hFFFF_FFF0, 16'd1234, 0, 0, 1, 2);
		row_want(ACT_CHECK, 32'h0000_0010, 16'd0, 1, 1234, 0, 1);
		// zero window drops everything
		row_cfg(REG_WINDOW, '0);
		row_want(ACT_CHECK, 32'h0000_0010, 16'd5, 1, 0, 0, 0);
		// full table, widest window and budget
		row_cfg(REG_WINDOW, '1);
		row_cfg(REG_BUDGET, 31'h00FF_FFFF);
		row_req(ACT_RECORD, 32'd5, 16'hFFFF, MAX_REC);
		row_want(ACT_RECORD, 32'd6, 16'hFFFF, 0, 24'hFFFF00, 0, MAX_REC);
		row_want(ACT_CHECK, 32'd6, 16'hFFFF, 0, 24'hFFFF00, 0, MAX_REC);
		row_want(ACT_CHECK, 32'd6, 16'd255, 1, 24'hFFFF00, 0, MAX_REC);
		row_want(ACT_CHECK, 32'h8000_0004, 16'd0, 1, 0, 0, 0);
		row_req(ACT_RECORD, 32'h8000_0004, 16'd0, 1);
		row_cfg(REG_BUDGET, '0);
		row_req(ACT_CHECK, 32'h8000_0004, 16'd0, 1);
		row_req(ACT_CHECK, 32'h8000_0004, 16'd1, 1);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				flush_results();
				write_reg(plan[i].sel, plan[i].val);
			end else begin
				repeat (plan[i].reps) send_req(plan[i].item, plan[i].known, plan[i].want);
			end
		end

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					win = 31'd1000; bud = 24'd5000; count = 170;
					step_hi = 60; rec_pct = 60; air_hi = 400;
				end
				1: begin
					win = '1; bud = USED_MAX; count = 110;
					step_hi = 1000; rec_pct = 70; air_hi = 16'hFFFF;
				end
				2: begin
					win = 31'd1; bud = '0; count = 90;
					step_hi = 2; rec_pct = 50; air_hi = 3;
				end
				3: begin
					win = WIN_W'($urandom_range(1, 100000));
					bud = USED_W'($urandom_range(0, 20000));
					count = 130; step_hi = 500; rec_pct = 55; air_hi = 2000;
				end
				default: begin
					win = WIN_W'($urandom_range(1, 32'h7FFF_FFFF));
					bud = USED_W'($urandom_range(0, USED_MAX));
					count = 125; step_hi = 65535; rec_pct = 50; air_hi = 16'hFFFF;
				end
			endcase
			flush_results();
			write_reg(REG_WINDOW, win);
			write_reg(REG_BUDGET, {{(WIN_W-USED_W){1'b0}}, bud});
			t_now = (ph % 2 == 1) ? 32'hFFFF_F000 : $urandom;
			for (int k = 0; k < count; k++) begin
				if (k % 40 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				// hold off until the block has answered everything
				if ($urandom_range(0, 79) == 0 || (ph == 0 && k == 120))
					flush_results();
				if ($urandom_range(0, 9) == 0) begin
					item.action = 1'($urandom_range(0, 1));
					item.now_ms = $urandom;
					item.duration_ms = AIR_W'($urandom);
				end else begin
					t_now += $urandom_range(0, step_hi);
					item.action = ($urandom_range(0, 99) < rec_pct) ? ACT_RECORD : ACT_CHECK;
					item.now_ms = t_now;
					case ($urandom_range(0, 4))
						0: item.duration_ms = AIR_W'($urandom);
						1: item.duration_ms = $urandom_range(0, 1) ? '1 : '0;
						default: item.duration_ms = AIR_W'($urandom_range(0, air_hi));
					endcase
				end
				send_req(item, 1'b0, '0);
			end
		end

		quiet = 1'b0;
		flush_results();
		repeat (300) @(posedge clk);
		$display("covered %0d checks (%0d refused) and %0d records (%0d dropped on a full table)",
			n_checks, n_denied, n_records, n_drops);
		$display("%0d register writes, %0d results compared, %0d mismatches", n_cfg, rsp_seen,
			errors);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/adcg_pkg.sv
design/adcg_ram.sv
design/adcg_ctrl.sv
design/adcg_dp.sv
design/airtime_duty_cycle_guard_top.sv
tb/sv/airtime_duty_cycle_guard_top_test.sv
